// ===== hdl/bfip_pkg.sv =====
`timescale 1ns / 1ps

package bfip_pkg;

	// fixed field widths
	localparam int PIX_W   = 8;
	localparam int SUM_W   = PIX_W + 1;
	localparam int CFG_W   = 11;
	localparam int LEVEL_W = 2;
	localparam int SIZE_W  = 13;

	// register indexes of the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// reset frame size
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	// pyramid level codes
	localparam logic [LEVEL_W-1:0] LVL0 = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL1 = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL2 = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL3 = 2'd3;

	// usable frame size: clamped to the maximum, multiple of 8, at least 8
	function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] t;
		t = ({2'b00, v} > maxv) ? maxv : {2'b00, v};
		t = t & ~13'd7;
		if (t < 13'd8) begin
			t = 13'd8;
		end
		return t;
	endfunction

endpackage

// ===== hdl/bfip_ram.sv =====
`timescale 1ns / 1ps

module bfip_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/box_filter_image_pyramid.sv =====
`timescale 1ns / 1ps

// Four-level 2x2 box-filter pyramid on a raster stream of 8-bit pixels. Every
// input pixel comes back as a level 0 result; the pixel that closes a 2x2 block
// also yields the level 1 average (sum / 4, truncated), and in turn level 2 and
// level 3 when it closes blocks there. Results of one pixel leave in level order
// and the last one carries run_last. An input pixel is taken every clock as long
// as the result port keeps up: the single result port moves one result per
// cycle, so a pixel with n results (1 to 4, about 1.33 on average over a frame)
// holds the input until its last result has gone. Input passes three pipeline
// stages, then the result buffer; each stage reads a line store of pair sums
// kept in synchronous RAM with a registered read. Level 0 sums have a RAM of
// MAX_WIDTH/2 entries; level 1 and level 2 sums share one RAM of MAX_WIDTH/4 +
// MAX_WIDTH/8 entries, as consecutive pixels never access both. The user must
// set the frame size via the configuration port only while the block is idle;
// the block does not enforce this. frame_start restarts the position count.
module box_filter_image_pyramid #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bfip_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bfip_pkg::PIX_W-1:0]    pixel_value,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bfip_pkg::LEVEL_W-1:0]  out_level,
	output logic [bfip_pkg::PIX_W-1:0]    out_pixel,
	output logic                          run_last
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int D1  = MAX_WIDTH / 2;
	localparam int D2  = MAX_WIDTH / 4;
	localparam int D3  = MAX_WIDTH / 8;
	localparam int D23 = D2 + D3;
	localparam int A1  = (D1 > 1) ? $clog2(D1) : 1;
	localparam int A2  = (D2 > 1) ? $clog2(D2) : 1;
	localparam int A3  = (D3 > 1) ? $clog2(D3) : 1;
	localparam int A23 = (D23 > 1) ? $clog2(D23) : 1;
	localparam int PW  = bfip_pkg::PIX_W;
	localparam int SW  = bfip_pkg::SUM_W;
	localparam int LW  = bfip_pkg::LEVEL_W;

	// effective frame size
	logic [CW-1:0] w_eff_q;
	logic [HW-1:0] h_eff_q;

	// position of the next pixel
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	// left pixel of the open horizontal pair per level
	logic [PW-1:0] hold0_q, hold1_q, hold2_q;

	// handshake and stage control
	logic in_xfer, out_xfer, adv, buf_free, buf_load;

	// input stage signals
	logic [CW-1:0] col_w, col_inc;
	logic [HW-1:0] row_w, row_inc;
	logic [XW-1:0] c0, c_sh1, c_sh2, c_sh3;
	logic [YW-1:0] r0;
	logic [SW-1:0] pair0;

	// pipeline stage registers
	logic          valid_s1, valid_s2, valid_s3;
	logic [XW-1:0] col_s1, col_s2;
	logic [YW-1:0] row_s1, row_s2;
	logic [PW-1:0] pix_s1, pix_s2, pix_s3;
	logic [PW-1:0] p1_s2, p1_s3, p2_s3;
	logic [SW-1:0] pair0_s1, pair1_s2, pair2_s3;
	logic          has1_s1, has1_s2, has1_s3;
	logic          has2_s2, has2_s3, has3_s3;

	// stage logic
	logic [PW-1:0]  p1, p2, p3;
	logic [SW-1:0]  pair1, pair2;
	logic [SW-1:0]  l1_rd, l23_rd, l23_wdata;
	logic [A23-1:0] l23_addr;
	logic           l1_we, l1_re, l2_we, l2_re, l3_we, l3_re, l23_we, l23_re;
	logic [SW:0]    sum1, sum2, sum3;

	// result buffer
	logic          buf_valid_q;
	logic [LW-1:0] buf_idx_q, buf_last_q, last_lvl;
	logic [PW-1:0] buf_pix_q [4];

	// configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= CW'(bfip_pkg::eff_size(bfip_pkg::WIDTH_RESET, 13'(MAX_WIDTH)));
			h_eff_q <= HW'(bfip_pkg::eff_size(bfip_pkg::HEIGHT_RESET, 13'(MAX_HEIGHT)));
		end else if (cfg_valid) begin
			case (cfg_index)
				bfip_pkg::REG_FRAME_WIDTH:
					w_eff_q <= CW'(bfip_pkg::eff_size(cfg_data, 13'(MAX_WIDTH)));
				bfip_pkg::REG_FRAME_HEIGHT:
					h_eff_q <= HW'(bfip_pkg::eff_size(cfg_data, 13'(MAX_HEIGHT)));
				default: ;
			endcase
		end
	end

	// stage advance and result buffer handoff
	assign out_xfer = buf_valid_q & out_ready;
	assign buf_free = ~buf_valid_q | (out_xfer & run_last);
	assign adv      = ~valid_s3 | buf_free;
	assign buf_load = valid_s3 & buf_free;
	assign in_ready = adv;
	assign in_xfer  = in_valid & adv;

	// position of the incoming pixel and of the one after it
	always_comb begin
		col_w = frame_start ? '0 : CW'(col_q);
		row_w = frame_start ? '0 : HW'(row_q);
		if (col_w >= w_eff_q) begin
			col_w = '0;
			row_w = row_w + 1'b1;
		end
		if (row_w >= h_eff_q) begin
			row_w = '0;
		end
		col_inc = col_w + 1'b1;
		row_inc = row_w + 1'b1;
	end

	assign c0    = col_w[XW-1:0];
	assign r0    = row_w[YW-1:0];
	assign c_sh1 = c0 >> 1;
	assign pair0 = SW'(hold0_q) + SW'(pixel_value);
	assign l1_we = in_xfer & c0[0] & ~r0[0];
	assign l1_re = in_xfer & c0[0] & r0[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_inc >= w_eff_q) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff_q) ? '0 : row_inc[YW-1:0];
			end else begin
				col_q <= col_inc[XW-1:0];
				row_q <= r0;
			end
		end
	end

	// level 0 pair sums: written on even rows, read on odd rows
	bfip_ram #(.WIDTH(SW), .DEPTH(D1)) u_l1_line (
		.clk   (clk),
		.we    (l1_we),
		.waddr (c_sh1[A1-1:0]),
		.wdata (pair0),
		.re    (l1_re),
		.raddr (c_sh1[A1-1:0]),
		.rdata (l1_rd)
	);

	// stage 1 result: level 1 pixel and level 1 pair
	assign sum1   = (SW + 1)'(l1_rd) + (SW + 1)'(pair0_s1);
	assign p1     = sum1[SW:2];
	assign pair1  = SW'(hold1_q) + SW'(p1);
	assign c_sh2  = col_s1 >> 2;
	assign l2_we  = adv & valid_s1 & has1_s1 & col_s1[1] & ~row_s1[1];
	assign l2_re  = adv & valid_s1 & has1_s1 & col_s1[1] & row_s1[1];

	// stage 2 result: level 2 pixel and level 2 pair
	assign sum2   = (SW + 1)'(l23_rd) + (SW + 1)'(pair1_s2);
	assign p2     = sum2[SW:2];
	assign pair2  = SW'(hold2_q) + SW'(p2);
	assign c_sh3  = col_s2 >> 3;
	assign l3_we  = adv & valid_s2 & has2_s2 & col_s2[2] & ~row_s2[2];
	assign l3_re  = adv & valid_s2 & has2_s2 & col_s2[2] & row_s2[2];

	// level 1 and level 2 pair sums share one RAM, level 2 above the level 1 part;
	// a level 2 access needs column bits 2:0 set, so the pixel behind it is at an
	// even column and cannot touch the level 1 part in the same cycle
	assign l23_we    = l2_we | l3_we;
	assign l23_re    = l2_re | l3_re;
	assign l23_wdata = l3_we ? pair2 : pair1;
	assign l23_addr  = (l3_we | l3_re) ? A23'(D2) + A23'(c_sh3[A3-1:0])
		: A23'(c_sh2[A2-1:0]);

	bfip_ram #(.WIDTH(SW), .DEPTH(D23)) u_l23_line (
		.clk   (clk),
		.we    (l23_we),
		.waddr (l23_addr),
		.wdata (l23_wdata),
		.re    (l23_re),
		.raddr (l23_addr),
		.rdata (l23_rd)
	);

	// stage 3 result: level 3 pixel
	assign sum3 = (SW + 1)'(l23_rd) + (SW + 1)'(pair2_s3);
	assign p3   = sum3[SW:2];

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// pipeline payload and pair holds
	always_ff @(posedge clk) begin
		if (in_xfer && !c0[0]) begin
			hold0_q <= pixel_value;
		end
		if (adv && valid_s1 && has1_s1 && !col_s1[1]) begin
			hold1_q <= p1;
		end
		if (adv && valid_s2 && has2_s2 && !col_s2[2]) begin
			hold2_q <= p2;
		end
		if (adv) begin
			col_s1   <= c0;
			row_s1   <= r0;
			pix_s1   <= pixel_value;
			pair0_s1 <= pair0;
			has1_s1  <= c0[0] & r0[0];

			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pix_s2   <= pix_s1;
			p1_s2    <= p1;
			pair1_s2 <= pair1;
			has1_s2  <= has1_s1;
			has2_s2  <= has1_s1 & col_s1[1] & row_s1[1];

			pix_s3   <= pix_s2;
			p1_s3    <= p1_s2;
			p2_s3    <= p2;
			pair2_s3 <= pair2;
			has1_s3  <= has1_s2;
			has2_s3  <= has2_s2;
			has3_s3  <= has2_s2 & col_s2[2] & row_s2[2];
		end
	end

	// highest level that the pixel in stage 3 completes
	always_comb begin
		if (has3_s3) begin
			last_lvl = bfip_pkg::LVL3;
		end else if (has2_s3) begin
			last_lvl = bfip_pkg::LVL2;
		end else if (has1_s3) begin
			last_lvl = bfip_pkg::LVL1;
		end else begin
			last_lvl = bfip_pkg::LVL0;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			buf_idx_q   <= bfip_pkg::LVL0;
			buf_last_q  <= bfip_pkg::LVL0;
		end else if (buf_load) begin
			buf_valid_q <= 1'b1;
			buf_idx_q   <= bfip_pkg::LVL0;
			buf_last_q  <= last_lvl;
		end else if (out_xfer) begin
			if (run_last) begin
				buf_valid_q <= 1'b0;
			end else begin
				buf_idx_q <= buf_idx_q + 1'b1;
			end
		end
	end

	// result buffer pixels
	always_ff @(posedge clk) begin
		if (buf_load) begin
			buf_pix_q[0] <= pix_s3;
			buf_pix_q[1] <= p1_s3;
			buf_pix_q[2] <= p2_s3;
			buf_pix_q[3] <= p3;
		end
	end

	assign out_valid = buf_valid_q;
	assign out_level = buf_idx_q;
	assign out_pixel = buf_pix_q[buf_idx_q];
	assign run_last  = (buf_idx_q == buf_last_q);

`ifndef SYNTH
	// a result transfer that is not the last is followed by the next level
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid && out_level == $past(out_level) + 1'b1)
		else $error("result level did not step after a transfer");

	// a pending result that is not taken stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_pixel))
		else $error("pending result changed without a transfer");

	// a stalled stage 3 keeps its item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv |=> valid_s3 && $stable(pix_s3) && $stable(has1_s3))
		else $error("stage 3 item lost during stall");

	// input is only taken when the pipeline moves
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !valid_s3 || !buf_valid_q || (out_ready && run_last))
		else $error("input taken while stage 3 is blocked");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;

	typedef struct packed {
		logic [bfip_pkg::LEVEL_W-1:0] level;
		logic [bfip_pkg::PIX_W-1:0]   pixel;
		logic                         last;
	} pyr_result_t;

	// pyramid predictor plus queue of results still owed by the block
	class pyramid_scoreboard;
		logic [bfip_pkg::CFG_W-1:0] width_reg;
		logic [bfip_pkg::CFG_W-1:0] height_reg;
		int unsigned                col;
		int unsigned                row;
		logic [bfip_pkg::PIX_W-1:0] pair_left[3];
		logic [bfip_pkg::SUM_W-1:0] pair_sums[3][MAX_W/2];
		pyr_result_t                pending[$];
		int unsigned                errors;
		int unsigned                pixels;
		int unsigned                writes;
		int unsigned                per_level[4];

		function new();
			width_reg = bfip_pkg::WIDTH_RESET;
			height_reg = bfip_pkg::HEIGHT_RESET;
			col = 0;
			row = 0;
			errors = 0;
			pixels = 0;
			writes = 0;
			foreach (per_level[i]) per_level[i] = 0;
			foreach (pair_left[k]) pair_left[k] = '0;
			foreach (pair_sums[k, i]) pair_sums[k][i] = '0;
		endfunction

		// clamp, round down to a multiple of 8, at least 8
		function int unsigned usable(int unsigned v, int unsigned maxv);
			if (v > maxv) v = maxv;
			v = (v / 8) * 8;
			if (v < 8) v = 8;
			return v;
		endfunction

		function int unsigned width_now();
			return usable(width_reg, MAX_W);
		endfunction

		function void write_reg(logic idx, logic [bfip_pkg::CFG_W-1:0] data);
			if (idx == bfip_pkg::REG_FRAME_WIDTH) begin
				width_reg = data;
			end else begin
				height_reg = data;
			end
			writes++;
		endfunction

		// one pixel of level k; returns 1 when it closes a 2x2 block
		function bit fold(int k, int unsigned c, int unsigned r, int unsigned p,
			output int unsigned avg);
			int unsigned pair;
			int unsigned idx;
			avg = 0;
			if (c % 2 == 0) begin
				pair_left[k] = p;
				return 0;
			end
			pair = pair_left[k] + p;
			idx = (c / 2) % ((MAX_W / 2) >> k);
			if (r % 2 == 0) begin
				pair_sums[k][idx] = pair;
				return 0;
			end
			avg = ((pair_sums[k][idx] + pair) / 4) % 256;
			return 1;
		endfunction

		// accepted input transfer: work out every result it causes
		function void take_pixel(logic [bfip_pkg::PIX_W-1:0] p, logic fs);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned r;
			int unsigned v1;
			int unsigned v2;
			int unsigned v3;
			pyr_result_t res[$];
			w = usable(width_reg, MAX_W);
			h = usable(height_reg, MAX_H);
			if (fs) begin
				col = 0;
				row = 0;
			end
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h) row = 0;
			c = col;
			r = row;
			res.push_back(pyr_result_t'{bfip_pkg::LVL0, p, 1'b0});
			if (fold(0, c, r, p, v1)) begin
				res.push_back(pyr_result_t'{bfip_pkg::LVL1, bfip_pkg::PIX_W'(v1), 1'b0});
				if (fold(1, c / 2, r / 2, v1, v2)) begin
					res.push_back(pyr_result_t'{bfip_pkg::LVL2, bfip_pkg::PIX_W'(v2), 1'b0});
					if (fold(2, c / 4, r / 4, v2, v3)) begin
						res.push_back(pyr_result_t'{bfip_pkg::LVL3,
							bfip_pkg::PIX_W'(v3), 1'b0});
					end
				end
			end
			res[res.size() - 1].last = 1'b1;
			foreach (res[i]) pending.push_back(res[i]);
			pixels++;
			col = c + 1;
			if (col >= w) begin
				col = 0;
				row = r + 1;
				if (row >= h) row = 0;
			end
		endfunction

		// accepted output transfer against the oldest expectation
		function void check_result(logic [bfip_pkg::LEVEL_W-1:0] lvl,
			logic [bfip_pkg::PIX_W-1:0] pix, logic last);
			pyr_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result level %0d pixel %0d last %0b",
					$time, lvl, pix, last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (lvl !== want.level || pix !== want.pixel || last !== want.last) begin
				$display("%0t: mismatch expected level %0d pixel %0d last %0b,",
					$time, want.level, want.pixel, want.last,
					" got level %0d pixel %0d last %0b", lvl, pix, last);
				errors++;
			end
			if (!$isunknown(lvl)) per_level[lvl]++;
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_index = bfip_pkg::REG_FRAME_WIDTH;
	logic [bfip_pkg::CFG_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [bfip_pkg::PIX_W-1:0]    pixel_value = '0;
	logic                          frame_start = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [bfip_pkg::LEVEL_W-1:0]  out_level;
	logic [bfip_pkg::PIX_W-1:0]    out_pixel;
	logic                          run_last;

	pyramid_scoreboard   sb;
	bit                  calm_in = 1'b0;
	bit                  calm_out = 1'b0;
	int unsigned         stall_left = 0;
	int unsigned         phases = 0;

	box_filter_image_pyramid #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_value(pixel_value),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_level  (out_level),
		.out_pixel  (out_pixel),
		.run_last   (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// raw register value: in range, off the grid of 8, or below the minimum
	function automatic logic [bfip_pkg::CFG_W-1:0] pick_size(int unsigned top);
		case ($urandom_range(0, 5))
			0: return bfip_pkg::CFG_W'($urandom_range(0, 7));
			1: return bfip_pkg::CFG_W'($urandom_range(1, top / 8) * 8 + $urandom_range(1, 7));
			default: return bfip_pkg::CFG_W'($urandom_range(1, top / 8) * 8);
		endcase
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (calm_out || $urandom_range(0, 99) < 75) begin
			out_ready = 1'b1;
		end else begin
			out_ready = 1'b0;
			stall_left = pick_gap() - 1;
		end
	end

	// output transfer monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_level, out_pixel, run_last);
		end
	end

	// one input transfer, entered and left at a falling edge
	task automatic send_pixel(input logic [bfip_pkg::PIX_W-1:0] p, input logic fs);
		int unsigned gap;
		gap = (calm_in || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		pixel_value = p;
		frame_start = fs;
		do @(posedge clk); while (!in_ready);
		sb.take_pixel(p, fs);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [bfip_pkg::CFG_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until every owed result has come out
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	// new frame size, then a stretch of pixels
	task automatic run_phase(input logic [bfip_pkg::CFG_W-1:0] w_raw,
		input logic [bfip_pkg::CFG_W-1:0] h_raw,
		input int unsigned count, input int unsigned flavor);
		int unsigned old_w;
		logic fs;
		logic [bfip_pkg::PIX_W-1:0] p;
		old_w = sb.width_now();
		if ($urandom_range(0, 1)) begin
			write_reg(bfip_pkg::REG_FRAME_WIDTH, w_raw);
			write_reg(bfip_pkg::REG_FRAME_HEIGHT, h_raw);
		end else begin
			write_reg(bfip_pkg::REG_FRAME_HEIGHT, h_raw);
			write_reg(bfip_pkg::REG_FRAME_WIDTH, w_raw);
		end
		calm_in = ($urandom_range(0, 3) == 0);
		calm_out = ($urandom_range(0, 3) == 0);
		phases++;
		for (int i = 0; i < count; i++) begin
			// a wider row needs a fresh frame so odd rows find their pair sums
			fs = (i == 0 && (sb.width_now() > old_w || $urandom_range(0, 1) == 1))
				|| ($urandom_range(0, 59) == 0);
			case (flavor)
				1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2: p = $urandom_range(250, 255);
				3: p = $urandom_range(0, 5);
				default: p = $urandom_range(0, 255);
			endcase
			send_pixel(p, fs);
		end
		drain();
	endtask

	initial begin
		logic [bfip_pkg::PIX_W-1:0] two_rows[16];
		int unsigned span;
		two_rows = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFE, 8'hFE};
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset frame size: pass-through only
		calm_in = 1'b1;
		calm_out = 1'b1;
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		drain();

		// sizes rounded up and down, then two rows with full, empty and truncated blocks
		write_reg(bfip_pkg::REG_FRAME_WIDTH, 11'd3);
		write_reg(bfip_pkg::REG_FRAME_HEIGHT, 11'd13);
		calm_in = 1'b0;
		calm_out = 1'b0;
		foreach (two_rows[i]) send_pixel(two_rows[i], i == 0);
		drain();

		// largest sizes, then narrowest row with tallest frame
		run_phase(11'h7FF, 11'd1024, 30, 0);
		run_phase(11'd8, 11'h7FF, 40, 2);

		// random small frame settings, each with a stretch of pixels
		while (sb.pixels < 310) begin
			span = $urandom_range(30, 90);
			if (span > 310 - sb.pixels) span = 310 - sb.pixels;
			run_phase(pick_size(32), pick_size(24), span,
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		end

		$display("run covered %0d pixels over %0d frame settings and %0d register writes",
			sb.pixels, phases + 2, sb.writes);
		$display("results checked per level 0..3: %0d %0d %0d %0d",
			sb.per_level[0], sb.per_level[1], sb.per_level[2], sb.per_level[3]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bfip_pkg.sv
hdl/bfip_ram.sv
hdl/box_filter_image_pyramid.sv
tb/tb_top.sv
